// ===== design/ffx_pkg.sv =====
package ffx_pkg;

    localparam logic [7:0] FLAG_BYTE  = 8'h7e;
    localparam logic [7:0] ESC_BYTE   = 8'h7d;
    localparam logic [7:0] ESC_OF_ESC = 8'h01;
    localparam logic [7:0] ESC_OF_FLG = 8'h02;

    localparam int MAX_RESULTS = 6;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    typedef struct packed {
        logic       two;
        logic [7:0] first;
        logic [7:0] second;
    } escape_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
        logic                        closes;
    } seq_t;

    function automatic escape_t escape_byte(input logic [7:0] b);
        escape_t e;
        e.two    = 1'b0;
        e.first  = b;
        e.second = 8'h00;
        if (b == ESC_BYTE)
        begin
            e.two    = 1'b1;
            e.first  = ESC_BYTE;
            e.second = ESC_OF_ESC;
        end
        else if (b == FLAG_BYTE)
        begin
            e.two    = 1'b1;
            e.first  = ESC_BYTE;
            e.second = ESC_OF_FLG;
        end
        return e;
    endfunction

endpackage

// ===== design/ffx_expand.sv =====
module ffx_expand (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // data_byte
    input  logic          s_tlast,   // frame_end
    output logic          seq_valid,
    input  logic          seq_ready,
    output ffx_pkg::seq_t seq
);

    logic       item_valid_reg;
    logic [7:0] item_byte_reg;
    logic       item_end_reg;
    logic       inside_reg;
    logic [7:0] check_reg;
    logic [7:0] chk_next;
    logic       xfer;
    logic [ffx_pkg::CNT_W-1:0] n;
    ffx_pkg::escape_t e_data;
    ffx_pkg::escape_t e_chk;

    assign xfer      = item_valid_reg && seq_ready;
    assign s_tready  = !item_valid_reg || seq_ready;
    assign seq_valid = item_valid_reg;
    assign chk_next  = check_reg ^ item_byte_reg;

    always_comb
    begin
        e_data     = ffx_pkg::escape_byte(item_byte_reg);
        e_chk      = ffx_pkg::escape_byte(chk_next);
        seq        = '0;
        n          = '0;
        if (!inside_reg)
        begin
            seq.bytes[n[ffx_pkg::IDX_W-1:0]] = ffx_pkg::FLAG_BYTE;
            n = n + 1'b1;
        end
        seq.bytes[n[ffx_pkg::IDX_W-1:0]] = e_data.first;
        n = n + 1'b1;
        if (e_data.two)
        begin
            seq.bytes[n[ffx_pkg::IDX_W-1:0]] = e_data.second;
            n = n + 1'b1;
        end
        if (item_end_reg)
        begin
            seq.bytes[n[ffx_pkg::IDX_W-1:0]] = e_chk.first;
            n = n + 1'b1;
            if (e_chk.two)
            begin
                seq.bytes[n[ffx_pkg::IDX_W-1:0]] = e_chk.second;
                n = n + 1'b1;
            end
            seq.bytes[n[ffx_pkg::IDX_W-1:0]] = ffx_pkg::FLAG_BYTE;
            n = n + 1'b1;
            seq.closes = 1'b1;
        end
        seq.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            inside_reg     <= 1'b0;
            check_reg      <= 8'h00;
        end
        else
        begin
            if (s_tvalid && s_tready)
                item_valid_reg <= 1'b1;
            else if (xfer)
                item_valid_reg <= 1'b0;
            if (xfer)
            begin
                inside_reg <= !item_end_reg;
                check_reg  <= item_end_reg ? 8'h00 : chk_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_byte_reg <= s_tdata;
            item_end_reg  <= s_tlast;
        end
    end

endmodule

// ===== design/ffx_emit.sv =====
module ffx_emit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          seq_valid,
    output logic          seq_ready,
    input  ffx_pkg::seq_t seq,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // out_byte
    output logic          m_tlast    // frame_last
);

    ffx_pkg::seq_t             seq_reg;
    logic [ffx_pkg::IDX_W-1:0] idx_reg;
    logic                      busy_reg;
    logic                      out_valid_reg;
    logic [7:0]                out_byte_reg;
    logic                      out_last_reg;
    logic                      load_ok;
    logic                      at_end;

    assign load_ok   = !out_valid_reg || m_tready;
    assign at_end    = ({1'b0, idx_reg} + 1'b1) == seq_reg.count;
    assign seq_ready = !busy_reg || (load_ok && at_end);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_byte_reg;
    assign m_tlast   = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (busy_reg && load_ok)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (seq_valid && seq_ready)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (busy_reg && load_ok)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (at_end)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && load_ok)
        begin
            out_byte_reg <= seq_reg.bytes[idx_reg];
            out_last_reg <= seq_reg.closes && at_end;
        end
        if (seq_valid && seq_ready)
            seq_reg <= seq;
    end

endmodule

// ===== design/flag_framer_escape_xor_check.sv =====
// An input item passes the expander's item register, the emitter's byte sequence
// register and its output register. Throughput: an input item produces 1 to 6 output
// bytes, one per cycle while m_tready is high; one-byte items then run every cycle.
// The emitter's byte sequence register and output register set the rate.
// Reset (rst_n, async, active low) empties all stages; the next item opens a new frame.
module flag_framer_escape_xor_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tlast,   // frame_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast    // frame_last
);

    logic          seq_valid;
    logic          seq_ready;
    ffx_pkg::seq_t seq;

    ffx_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .seq_valid (seq_valid),
        .seq_ready (seq_ready),
        .seq       (seq)
    );

    ffx_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .seq_valid (seq_valid),
        .seq_ready (seq_ready),
        .seq       (seq),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTH
    a_close_is_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == ffx_pkg::FLAG_BYTE)
        else $error("closing byte is not the flag");

    a_seq_count: assert property (@(posedge clk) disable iff (!rst_n)
        seq_valid |-> seq.count != '0 && seq.count <= ffx_pkg::CNT_W'(ffx_pkg::MAX_RESULTS))
        else $error("byte sequence count out of range");

    a_seq_hold: assert property (@(posedge clk) disable iff (!rst_n)
        seq_valid && !seq_ready |=> seq_valid && $stable(seq))
        else $error("pending byte sequence changed");
`endif

endmodule
